// ----- sv/step_dir_generator_backlash_macros.svh -----
// assertion macros for the step/direction generator
`ifndef STEP_DIR_GENERATOR_BACKLASH_MACROS_SVH
`define STEP_DIR_GENERATOR_BACKLASH_MACROS_SVH
`ifndef SYNTHESIS
`define SDGB_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define SDGB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SDGB_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define SDGB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- sv/sdgb_pkg.sv -----
// types, constants and helpers shared by the step/direction generator
`default_nettype none
package sdgb_pkg;

    localparam int POS_W       = 32;
    localparam int CFG_ADDR_W  = 5;
    localparam int APB_DATA_W  = 32;
    localparam int REG_IDX_W   = 3;
    localparam int BACKLASH_W  = 16;

    typedef enum logic [1:0] {
        CMD_TICK     = 2'd0,
        CMD_LOAD     = 2'd1,
        CMD_SLEW_REQ = 2'd2,
        CMD_TRACK    = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        DIR_IDLE = 2'd0,
        DIR_FWD  = 2'd1,
        DIR_REV  = 2'd2
    } t_dir;

    typedef enum logic [2:0] {
        MODE_TRACK   = 3'b001,
        MODE_REQUEST = 3'b010,
        MODE_READY   = 3'b100
    } t_mode;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_PULSE_MODE      = 3'd0,
        REG_INVERT_DIR      = 3'd1,
        REG_STEP_SIZE       = 3'd2,
        REG_TRACKING_RATE   = 3'd3,
        REG_SLEW_SIZE       = 3'd4,
        REG_BACKLASH_AMOUNT = 3'd5,
        REG_SLEW_RATIO_LOG2 = 3'd6,
        REG_TRACKING_ON     = 3'd7
    } t_reg;

    typedef struct packed {
        logic               pulse_mode;
        logic               invert_direction;
        logic [8:0]         step_size;
        logic signed [9:0]  tracking_rate;
        logic [8:0]         slew_size;
        logic [14:0]        backlash_amount;
        logic [3:0]         slew_ratio_log2;
        logic               tracking_on;
    } t_cfg;

    function automatic logic is_aligned(input logic [BACKLASH_W-1:0] motor_lo,
                                        input logic [BACKLASH_W-1:0] backlash,
                                        input logic [3:0] ratio_log2);
        logic [BACKLASH_W-1:0] sum;
        logic [BACKLASH_W-1:0] mask;
        sum  = motor_lo + backlash;
        mask = BACKLASH_W'((17'd1 << ratio_log2) - 17'd1);
        return (sum & mask) == '0;
    endfunction

endpackage
`default_nettype wire

// ----- sv/step_dir_generator_backlash.sv -----
// top level of the stepper step/direction generator with backlash take-up
//
// input channel (i_in_valid / o_in_ready) carries one command per transaction:
// tick, load target, request slewing microstep mode, or back to tracking.
// output channel (o_out_valid / i_out_ready) returns one result per command:
// pin levels, direction, motor, backlash and target counts, slew grant,
// all showing the state after that command.
// latency: the result is valid the cycle after the command is accepted.
// throughput: one command per cycle while results are taken; the state update
// is a single pass of add, compare and step logic between the state registers,
// which also serve as the output register.
// a stalled receiver holds the result; a new command is taken in the same
// cycle the waiting result is taken.
// reset clears positions, backlash and phase, sets direction none, tracking
// mode and both pins low; configuration returns to its defaults. The user must
// write configuration via the APB-style port only while idle, unchecked by the block.
`default_nettype none
`include "step_dir_generator_backlash_macros.svh"
module step_dir_generator_backlash (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [1:0]                       i_cmd,
    input  logic signed [31:0]               i_target_value,
    input  logic                             i_fast,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic                             o_step_level,
    output logic                             o_dir_level,
    output logic [1:0]                       o_move_direction,
    output logic signed [31:0]               o_motor_position,
    output logic [15:0]                      o_backlash_position,
    output logic signed [31:0]               o_target_position,
    output logic                             o_slew_ready,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [sdgb_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [sdgb_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [sdgb_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready
);
    import sdgb_pkg::*;

    t_cfg cfg;

    logic signed [POS_W-1:0]   r_motor,    n_motor;
    logic signed [POS_W-1:0]   r_target,   n_target;
    logic [BACKLASH_W-1:0]     r_backlash, n_backlash;
    t_dir                      r_dir,      n_dir;
    t_mode                     r_mode,     n_mode;
    logic                      r_phase,    n_phase;
    logic                      r_step_pin, n_step_pin;
    logic                      r_dir_pin,  n_dir_pin;
    logic                      r_out_valid;

    t_cmd                      w_cmd;
    logic                      w_in_acc;
    logic signed [POS_W-1:0]   w_load_target;
    logic signed [POS_W-1:0]   w_trk_target;
    logic signed [POS_W+1:0]   w_pos_sum;
    logic signed [POS_W+1:0]   w_trk_ext;
    t_dir                      w_dec_dir;
    logic [BACKLASH_W-1:0]     w_step16;
    logic [POS_W-1:0]          w_step_inc;
    logic [POS_W-1:0]          w_slew_inc;
    logic signed [POS_W-1:0]   w_fwd_motor, w_rev_motor;
    logic [BACKLASH_W-1:0]     w_fwd_backlash, w_rev_backlash;
    logic                      w_fwd_aligned, w_rev_aligned, w_cur_aligned;
    logic                      w_slew_fwd, w_slew_act;
    logic signed [POS_W-1:0]   w_slew_target;
    logic                      w_slew_lt, w_slew_gt;

    sdgb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_cmd      = t_cmd'(i_cmd);

    assign w_load_target = POS_W'(i_target_value);
    assign w_trk_target  = cfg.tracking_on ? r_target + POS_W'(cfg.tracking_rate) : r_target;

    // exact signed motor plus backlash against the target, no wrap
    assign w_pos_sum = (POS_W+2)'(r_motor) + (POS_W+2)'(signed'({1'b0, r_backlash}));
    assign w_trk_ext = (POS_W+2)'(w_trk_target);

    always_comb begin
        if (w_pos_sum < w_trk_ext) begin
            w_dec_dir = DIR_FWD;
        end else if (w_pos_sum > w_trk_ext) begin
            w_dec_dir = DIR_REV;
        end else begin
            w_dec_dir = DIR_IDLE;
        end
    end

    assign w_step16   = BACKLASH_W'(cfg.step_size);
    assign w_step_inc = POS_W'(cfg.step_size);
    assign w_slew_inc = POS_W'(cfg.slew_size);

    // forward: fill backlash first, then move the motor
    always_comb begin
        w_fwd_motor    = r_motor;
        w_fwd_backlash = r_backlash;
        if (r_backlash < BACKLASH_W'(cfg.backlash_amount)) begin
            w_fwd_backlash = r_backlash + w_step16;
        end else begin
            w_fwd_motor = r_motor + w_step_inc;
        end
    end

    // reverse: empty backlash first with saturation, then move the motor
    always_comb begin
        w_rev_motor    = r_motor;
        w_rev_backlash = r_backlash;
        if (r_backlash != '0) begin
            w_rev_backlash = (r_backlash > w_step16) ? r_backlash - w_step16 : '0;
        end else begin
            w_rev_motor = r_motor - w_step_inc;
        end
    end

    assign w_fwd_aligned = is_aligned(w_fwd_motor[BACKLASH_W-1:0], w_fwd_backlash,
                                      cfg.slew_ratio_log2);
    assign w_rev_aligned = is_aligned(w_rev_motor[BACKLASH_W-1:0], w_rev_backlash,
                                      cfg.slew_ratio_log2);
    assign w_cur_aligned = is_aligned(r_motor[BACKLASH_W-1:0], r_backlash,
                                      cfg.slew_ratio_log2);

    assign w_slew_fwd    = (r_dir == DIR_FWD);
    assign w_slew_act    = cfg.pulse_mode || r_phase;
    assign w_slew_target = !cfg.tracking_on ? r_target :
                           (w_slew_fwd ? r_target + w_slew_inc : r_target - w_slew_inc);
    assign w_slew_lt     = r_motor < w_slew_target;
    assign w_slew_gt     = r_motor > w_slew_target;

    always_comb begin
        n_motor    = r_motor;
        n_backlash = r_backlash;
        n_target   = r_target;
        n_dir      = r_dir;
        n_mode     = r_mode;
        n_phase    = r_phase;
        n_step_pin = r_step_pin;
        n_dir_pin  = r_dir_pin;
        if (w_in_acc) begin
            case (w_cmd)
                CMD_TICK: begin
                    if (i_fast) begin
                        n_step_pin = 1'b0;
                        if (w_slew_act) begin
                            n_target = w_slew_target;
                            if (w_slew_fwd && w_slew_lt) begin
                                n_motor    = r_motor + w_slew_inc;
                                n_step_pin = 1'b1;
                            end else if (!w_slew_fwd && w_slew_gt) begin
                                n_motor    = r_motor - w_slew_inc;
                                n_step_pin = 1'b1;
                            end
                        end
                        if (!cfg.pulse_mode) begin
                            n_phase = ~r_phase;
                        end
                    end else if (r_mode != MODE_READY) begin
                        if (cfg.pulse_mode) begin
                            n_step_pin = 1'b0;
                            n_target   = w_trk_target;
                            n_dir      = w_dec_dir;
                            case (w_dec_dir)
                                DIR_FWD: begin
                                    n_dir_pin  = cfg.invert_direction;
                                    n_motor    = w_fwd_motor;
                                    n_backlash = w_fwd_backlash;
                                    n_step_pin = 1'b1;
                                    if (r_mode == MODE_REQUEST && w_fwd_aligned) begin
                                        n_mode = MODE_READY;
                                    end
                                end
                                DIR_REV: begin
                                    n_dir_pin  = ~cfg.invert_direction;
                                    n_motor    = w_rev_motor;
                                    n_backlash = w_rev_backlash;
                                    n_step_pin = 1'b1;
                                    if (r_mode == MODE_REQUEST && w_rev_aligned) begin
                                        n_mode = MODE_READY;
                                    end
                                end
                                default: ;
                            endcase
                        end else if (r_phase) begin
                            case (r_dir)
                                DIR_FWD: begin
                                    n_motor    = w_fwd_motor;
                                    n_backlash = w_fwd_backlash;
                                    n_step_pin = 1'b1;
                                end
                                DIR_REV: begin
                                    n_motor    = w_rev_motor;
                                    n_backlash = w_rev_backlash;
                                    n_step_pin = 1'b1;
                                end
                                default: ;
                            endcase
                            n_phase = 1'b0;
                        end else begin
                            n_target   = w_trk_target;
                            n_dir      = w_dec_dir;
                            n_step_pin = 1'b0;
                            case (w_dec_dir)
                                DIR_FWD: n_dir_pin = cfg.invert_direction;
                                DIR_REV: n_dir_pin = ~cfg.invert_direction;
                                default: ;
                            endcase
                            if (r_mode == MODE_REQUEST && w_cur_aligned) begin
                                n_mode = MODE_READY;
                            end
                            n_phase = 1'b1;
                        end
                    end
                end
                CMD_LOAD: begin
                    n_target = w_load_target;
                end
                CMD_SLEW_REQ: begin
                    if (r_mode != MODE_READY) begin
                        n_mode = MODE_REQUEST;
                    end
                end
                CMD_TRACK: begin
                    n_mode = MODE_TRACK;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_motor     <= '0;
            r_backlash  <= '0;
            r_target    <= '0;
            r_dir       <= DIR_IDLE;
            r_mode      <= MODE_TRACK;
            r_phase     <= 1'b0;
            r_step_pin  <= 1'b0;
            r_dir_pin   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_motor    <= n_motor;
            r_backlash <= n_backlash;
            r_target   <= n_target;
            r_dir      <= n_dir;
            r_mode     <= n_mode;
            r_phase    <= n_phase;
            r_step_pin <= n_step_pin;
            r_dir_pin  <= n_dir_pin;
            if (w_in_acc) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_step_level        = r_step_pin;
    assign o_dir_level         = r_dir_pin;
    assign o_move_direction    = r_dir;
    assign o_motor_position    = 32'(r_motor);
    assign o_backlash_position = r_backlash;
    assign o_target_position   = 32'(r_target);
    assign o_slew_ready        = (r_mode == MODE_READY);

    // granted mode freezes normal ticks
    `SDGB_ASSERT_NEXT(a_ready_freeze, i_clk, i_rst_n, i_rst_n && w_in_acc && w_cmd == CMD_TICK && !i_fast && r_mode == MODE_READY, $stable(r_motor) && $stable(r_backlash) && $stable(r_target) && $stable(r_phase), "normal tick moved state while slew mode granted")
    // target load lands exactly
    `SDGB_ASSERT_NEXT(a_load_target, i_clk, i_rst_n, i_rst_n && w_in_acc && w_cmd == CMD_LOAD, r_target == $past(w_load_target), "target load mismatch")
    // step pin only rises on a tick transaction
    `SDGB_ASSERT_IMPL(a_step_on_tick, i_clk, i_rst_n, $rose(r_step_pin), $past(w_in_acc && w_cmd == CMD_TICK), "step pin rose without a tick")

endmodule
`default_nettype wire

// ----- sv/sdgb_regs.sv -----
// configuration register file behind the APB-style port
`default_nettype none
module sdgb_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [sdgb_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [sdgb_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [sdgb_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready,
    output sdgb_pkg::t_cfg                   o_cfg
);
    import sdgb_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;
    t_reg w_idx;
    logic w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg'(paddr[CFG_ADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite && pready;
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            case (w_idx)
                REG_PULSE_MODE:      n_cfg.pulse_mode       = pwdata[0];
                REG_INVERT_DIR:      n_cfg.invert_direction = pwdata[0];
                REG_STEP_SIZE:       n_cfg.step_size        = pwdata[8:0];
                REG_TRACKING_RATE:   n_cfg.tracking_rate    = signed'(pwdata[9:0]);
                REG_SLEW_SIZE:       n_cfg.slew_size        = pwdata[8:0];
                REG_BACKLASH_AMOUNT: n_cfg.backlash_amount  = pwdata[14:0];
                REG_SLEW_RATIO_LOG2: n_cfg.slew_ratio_log2  = pwdata[3:0];
                REG_TRACKING_ON:     n_cfg.tracking_on      = pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_PULSE_MODE:      prdata = APB_DATA_W'(r_cfg.pulse_mode);
            REG_INVERT_DIR:      prdata = APB_DATA_W'(r_cfg.invert_direction);
            REG_STEP_SIZE:       prdata = APB_DATA_W'(r_cfg.step_size);
            REG_TRACKING_RATE:   prdata = APB_DATA_W'(r_cfg.tracking_rate);
            REG_SLEW_SIZE:       prdata = APB_DATA_W'(r_cfg.slew_size);
            REG_BACKLASH_AMOUNT: prdata = APB_DATA_W'(r_cfg.backlash_amount);
            REG_SLEW_RATIO_LOG2: prdata = APB_DATA_W'(r_cfg.slew_ratio_log2);
            REG_TRACKING_ON:     prdata = APB_DATA_W'(r_cfg.tracking_on);
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            // unit step and slew sizes, everything else zero
            r_cfg <= {1'b0, 1'b0, 9'd1, 10'd0, 9'd1, 15'd0, 4'd0, 1'b0};
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule
`default_nettype wire

// ----- bench/step_dir_checker.sv -----
// checker for the step/direction generator: predicts every result and compares it field by field
`timescale 1ns / 1ps
module step_dir_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    input  logic                                 i_in_ready,
    input  logic [1:0]                           i_cmd,
    input  logic [31:0]                          i_target_value,
    input  logic                                 i_fast,
    input  logic                                 i_out_valid,
    input  logic                                 i_out_ready,
    input  logic                                 i_step_level,
    input  logic                                 i_dir_level,
    input  logic [1:0]                           i_move_direction,
    input  logic [31:0]                          i_motor_position,
    input  logic [15:0]                          i_backlash_position,
    input  logic [31:0]                          i_target_position,
    input  logic                                 i_slew_ready,
    input  logic                                 i_psel,
    input  logic                                 i_penable,
    input  logic                                 i_pwrite,
    input  logic [sdgb_pkg::CFG_ADDR_W-1:0]      i_paddr,
    input  logic [sdgb_pkg::APB_DATA_W-1:0]      i_pwdata,
    input  logic                                 i_pready,
    output int                                   o_fail_count,
    output int                                   o_pending
);
    import sdgb_pkg::*;

    typedef struct packed {
        logic        step_level;
        logic        dir_level;
        t_dir        move_dir;
        logic [31:0] motor;
        logic [15:0] backlash;
        logic [31:0] target;
        logic        slew_ready;
    } t_axis_state;

    t_cfg        cfg;
    logic [31:0] motor_cnt;
    logic [31:0] target_cnt;
    logic [15:0] backlash_cnt;
    t_dir        dir_now;
    logic        phase_high;
    t_mode       mode_now;
    logic        step_pin;
    logic        dir_pin;
    t_axis_state expected_q[$];
    int          mismatch_count = 0;

    assign o_fail_count = mismatch_count;

    function automatic void reset_axis();
        cfg           = '0;
        cfg.step_size = 9'd1;
        cfg.slew_size = 9'd1;
        motor_cnt     = '0;
        target_cnt    = '0;
        backlash_cnt  = '0;
        dir_now       = DIR_IDLE;
        phase_high    = 1'b0;
        mode_now      = MODE_TRACK;
        step_pin      = 1'b0;
        dir_pin       = 1'b0;
    endfunction

    function automatic void write_register(input t_reg idx, input logic [31:0] data);
        case (idx)
            REG_PULSE_MODE:      cfg.pulse_mode       = data[0];
            REG_INVERT_DIR:      cfg.invert_direction = data[0];
            REG_STEP_SIZE:       cfg.step_size        = data[8:0];
            REG_TRACKING_RATE:   cfg.tracking_rate    = data[9:0];
            REG_SLEW_SIZE:       cfg.slew_size        = data[8:0];
            REG_BACKLASH_AMOUNT: cfg.backlash_amount  = data[14:0];
            REG_SLEW_RATIO_LOG2: cfg.slew_ratio_log2  = data[3:0];
            default:             cfg.tracking_on      = data[0];
        endcase
    endfunction

    // forward steps fill the take-up span before the motor moves
    function automatic void take_up_forward();
        if (backlash_cnt < 16'(cfg.backlash_amount))
            backlash_cnt = backlash_cnt + 16'(cfg.step_size);
        else
            motor_cnt = motor_cnt + 32'(cfg.step_size);
    endfunction

    // reverse steps drain the take-up span first, saturating at zero
    function automatic void take_up_reverse();
        if (backlash_cnt != '0)
            backlash_cnt = (backlash_cnt > 16'(cfg.step_size)) ?
                           backlash_cnt - 16'(cfg.step_size) : '0;
        else
            motor_cnt = motor_cnt - 32'(cfg.step_size);
    endfunction

    function automatic void add_tracking();
        if (cfg.tracking_on)
            target_cnt = target_cnt + {{22{cfg.tracking_rate[9]}}, cfg.tracking_rate};
    endfunction

    // motor plus backlash compared without wrap
    function automatic void choose_direction();
        longint axis_sum;
        longint goal;
        axis_sum = longint'($signed(motor_cnt)) + longint'(backlash_cnt);
        goal     = longint'($signed(target_cnt));
        if (axis_sum < goal) begin
            dir_now = DIR_FWD;
            dir_pin = cfg.invert_direction;
        end else if (axis_sum > goal) begin
            dir_now = DIR_REV;
            dir_pin = ~cfg.invert_direction;
        end else begin
            dir_now = DIR_IDLE;
        end
    endfunction

    function automatic void check_alignment();
        logic [63:0] low_mask;
        logic [63:0] sum;
        low_mask = (64'd1 << cfg.slew_ratio_log2) - 64'd1;
        sum      = 64'(motor_cnt) + 64'(backlash_cnt);
        if (mode_now == MODE_REQUEST && (sum & low_mask) == '0)
            mode_now = MODE_READY;
    endfunction

    // fast slew ignores the grant and the backlash counter
    function automatic void slew_step();
        logic toward_fwd;
        logic active;
        toward_fwd = (dir_now == DIR_FWD);
        active     = cfg.pulse_mode | phase_high;
        step_pin   = 1'b0;
        if (active) begin
            if (cfg.tracking_on)
                target_cnt = toward_fwd ? target_cnt + 32'(cfg.slew_size) :
                                          target_cnt - 32'(cfg.slew_size);
            if (toward_fwd && $signed(motor_cnt) < $signed(target_cnt)) begin
                motor_cnt = motor_cnt + 32'(cfg.slew_size);
                step_pin  = 1'b1;
            end else if (!toward_fwd && $signed(motor_cnt) > $signed(target_cnt)) begin
                motor_cnt = motor_cnt - 32'(cfg.slew_size);
                step_pin  = 1'b1;
            end
        end
        if (!cfg.pulse_mode)
            phase_high = ~phase_high;
    endfunction

    function automatic void chase_step();
        if (mode_now == MODE_READY)
            return;
        if (cfg.pulse_mode) begin
            step_pin = 1'b0;
            add_tracking();
            choose_direction();
            if (dir_now != DIR_IDLE) begin
                if (dir_now == DIR_FWD)
                    take_up_forward();
                else
                    take_up_reverse();
                step_pin = 1'b1;
                check_alignment();
            end
        end else begin
            if (phase_high) begin
                if (dir_now == DIR_FWD) begin
                    take_up_forward();
                    step_pin = 1'b1;
                end else if (dir_now == DIR_REV) begin
                    take_up_reverse();
                    step_pin = 1'b1;
                end
            end else begin
                add_tracking();
                choose_direction();
                step_pin = 1'b0;
                check_alignment();
            end
            phase_high = ~phase_high;
        end
    endfunction

    function automatic t_axis_state apply_command(input t_cmd op, input logic [31:0] value,
                                                  input logic fast);
        t_axis_state r;
        case (op)
            CMD_TICK: begin
                if (fast)
                    slew_step();
                else
                    chase_step();
            end
            CMD_LOAD:     target_cnt = value;
            CMD_SLEW_REQ: if (mode_now != MODE_READY) mode_now = MODE_REQUEST;
            default:      mode_now = MODE_TRACK;
        endcase
        r.step_level = step_pin;
        r.dir_level  = dir_pin;
        r.move_dir   = dir_now;
        r.motor      = motor_cnt;
        r.backlash   = backlash_cnt;
        r.target     = target_cnt;
        r.slew_ready = (mode_now == MODE_READY);
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h expected %h", name, got, want));
    endtask

    task automatic compare_result(input t_axis_state want);
        check_field("step_level", 32'(i_step_level), 32'(want.step_level));
        check_field("dir_level", 32'(i_dir_level), 32'(want.dir_level));
        check_field("move_direction", 32'(i_move_direction), 32'(want.move_dir));
        check_field("motor_position", i_motor_position, want.motor);
        check_field("backlash_position", 32'(i_backlash_position), 32'(want.backlash));
        check_field("target_position", i_target_position, want.target);
        check_field("slew_ready", 32'(i_slew_ready), 32'(want.slew_ready));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_axis();
            expected_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready)
                write_register(t_reg'(i_paddr[CFG_ADDR_W-1:2]), i_pwdata);
            if (i_out_valid && i_out_ready) begin
                if (expected_q.size() == 0)
                    report_mismatch($sformatf("result transaction with nothing expected, motor %h",
                                              i_motor_position));
                else
                    compare_result(expected_q.pop_front());
            end
            if (i_in_valid && i_in_ready)
                expected_q.push_back(apply_command(t_cmd'(i_cmd), i_target_value, i_fast));
        end
        o_pending <= expected_q.size();
    end

endmodule

// ----- bench/testbench.sv -----
// testbench top for the step/direction generator: clock, reset, stimulus and verdict
`timescale 1ns / 1ps
module testbench;
    import sdgb_pkg::*;

    localparam int RANDOM_ITEMS = 1300;
    localparam int CYCLE_LIMIT  = 600000;

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  i_in_valid     = 1'b0;
    logic                  o_in_ready;
    logic [1:0]            i_cmd          = CMD_TICK;
    logic signed [31:0]    i_target_value = '0;
    logic                  i_fast         = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_ready    = 1'b0;
    logic                  o_step_level;
    logic                  o_dir_level;
    logic [1:0]            o_move_direction;
    logic signed [31:0]    o_motor_position;
    logic [15:0]           o_backlash_position;
    logic signed [31:0]    o_target_position;
    logic                  o_slew_ready;
    logic                  psel           = 1'b0;
    logic                  penable        = 1'b0;
    logic                  pwrite         = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr          = '0;
    logic [APB_DATA_W-1:0] pwdata         = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int   fail_count;
    int   pending;
    int   cycle_count = 0;
    int   hold_left   = 0;
    int   sent_count  = 0;
    logic gaps_on     = 1'b1;
    logic stalls_on   = 1'b1;

    step_dir_generator_backlash dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_cmd               (i_cmd),
        .i_target_value      (i_target_value),
        .i_fast              (i_fast),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_step_level        (o_step_level),
        .o_dir_level         (o_dir_level),
        .o_move_direction    (o_move_direction),
        .o_motor_position    (o_motor_position),
        .o_backlash_position (o_backlash_position),
        .o_target_position   (o_target_position),
        .o_slew_ready        (o_slew_ready),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready)
    );

    step_dir_checker checker_i (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .i_in_ready          (o_in_ready),
        .i_cmd               (i_cmd),
        .i_target_value      (i_target_value),
        .i_fast              (i_fast),
        .i_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .i_step_level        (o_step_level),
        .i_dir_level         (o_dir_level),
        .i_move_direction    (o_move_direction),
        .i_motor_position    (o_motor_position),
        .i_backlash_position (o_backlash_position),
        .i_target_position   (o_target_position),
        .i_slew_ready        (o_slew_ready),
        .i_psel              (psel),
        .i_penable           (penable),
        .i_pwrite            (pwrite),
        .i_paddr             (paddr),
        .i_pwdata            (pwdata),
        .i_pready            (pready),
        .o_fail_count        (fail_count),
        .o_pending           (pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic int pick_idle(input logic enabled);
        int roll;
        roll = $urandom_range(0, 99);
        if (!enabled || roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // receiver back-pressure
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (stalls_on && $urandom_range(0, 99) < 30) begin
            hold_left   <= pick_idle(1'b1);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    function automatic t_cfg pack_cfg(input logic pm, input logic inv, input int step,
                                      input int rate, input int slew, input int lash,
                                      input int ratio, input logic trk);
        t_cfg c;
        c.pulse_mode       = pm;
        c.invert_direction = inv;
        c.step_size        = 9'(step);
        c.tracking_rate    = 10'(rate);
        c.slew_size        = 9'(slew);
        c.backlash_amount  = 15'(lash);
        c.slew_ratio_log2  = 4'(ratio);
        c.tracking_on      = trk;
        return c;
    endfunction

    function automatic t_cfg random_cfg();
        int step;
        int rate;
        int slew;
        int lash;
        step = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 256) : $urandom_range(1, 12);
        rate = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 512)) - 256 :
                                             int'($urandom_range(0, 16)) - 8;
        slew = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 256) : $urandom_range(1, 16);
        lash = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 32767) : $urandom_range(0, 40);
        return pack_cfg(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), step, rate,
                        slew, lash, $urandom_range(0, 8), 1'($urandom_range(0, 1)));
    endfunction

    function automatic logic [31:0] near_target(input int span);
        int offset;
        offset = int'($urandom_range(0, 2 * span)) - span;
        return o_motor_position + offset;
    endfunction

    task automatic issue_command(input t_cmd op, input logic [31:0] value, input logic fast);
        int gap;
        gap = pick_idle(gaps_on);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_cmd          <= op;
        i_target_value <= value;
        i_fast         <= fast;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sent_count++;
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
    endtask

    task automatic write_config(input t_cfg c);
        wait_drained();
        write_reg(REG_PULSE_MODE, 32'(c.pulse_mode));
        write_reg(REG_INVERT_DIR, 32'(c.invert_direction));
        write_reg(REG_STEP_SIZE, 32'(c.step_size));
        write_reg(REG_TRACKING_RATE, {{22{c.tracking_rate[9]}}, c.tracking_rate});
        write_reg(REG_SLEW_SIZE, 32'(c.slew_size));
        write_reg(REG_BACKLASH_AMOUNT, 32'(c.backlash_amount));
        write_reg(REG_SLEW_RATIO_LOG2, 32'(c.slew_ratio_log2));
        write_reg(REG_TRACKING_ON, 32'(c.tracking_on));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial begin
        t_cfg cur;
        int   roll;
        int   span;
        int   next_phase;
        int   phase_no;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: square mode, unit steps, no backlash, no tracking
        repeat (2) issue_command(CMD_TICK, 32'h0, 1'b0);
        issue_command(CMD_LOAD, 32'd3, 1'b0);
        repeat (4) issue_command(CMD_TICK, 32'hFFFF_FFFF, 1'b0);
        repeat (2) issue_command(CMD_TICK, 32'h0, 1'b1);
        issue_command(CMD_SLEW_REQ, 32'h0, 1'b0);
        issue_command(CMD_TICK, 32'h0, 1'b0);
        issue_command(CMD_SLEW_REQ, 32'h0, 1'b1);
        issue_command(CMD_TICK, 32'h0, 1'b0);
        issue_command(CMD_TICK, 32'h0, 1'b1);
        issue_command(CMD_TRACK, 32'h0, 1'b0);
        issue_command(CMD_LOAD, 32'h8000_0000, 1'b0);
        repeat (2) issue_command(CMD_TICK, 32'h0, 1'b0);
        repeat (2) issue_command(CMD_TICK, 32'h0, 1'b1);
        issue_command(CMD_LOAD, 32'h7FFF_FFFF, 1'b1);
        issue_command(CMD_LOAD, 32'hFFFF_FFFF, 1'b0);
        issue_command(CMD_LOAD, 32'h0, 1'b0);

        sent_count = 0;
        next_phase = 0;
        phase_no   = 0;
        cur        = pack_cfg(1'b0, 1'b0, 1, 0, 1, 0, 0, 1'b0);
        while (sent_count < RANDOM_ITEMS) begin
            if (sent_count >= next_phase) begin
                case (phase_no)
                    0:       cur = pack_cfg(1'b1, 1'b1, 256, 256, 256, 32767, 8, 1'b1);
                    1:       cur = pack_cfg(1'b0, 1'b0, 0, -256, 0, 0, 0, 1'b1);
                    2:       cur = pack_cfg(1'b1, 1'b0, 3, -1, 2, 5, 3, 1'b0);
                    default: cur = random_cfg();
                endcase
                write_config(cur);
                // target wraps past the positive end while tracking
                if (phase_no == 0) begin
                    issue_command(CMD_LOAD, 32'h7FFF_FF80, 1'b0);
                    repeat (4) issue_command(CMD_TICK, $urandom(), 1'b0);
                end
                phase_no++;
                next_phase = sent_count + $urandom_range(60, 140);
                gaps_on   <= ($urandom_range(0, 3) != 0);
                stalls_on <= ($urandom_range(0, 3) != 0);
            end
            span = int'(cur.step_size) * int'($urandom_range(1, 10)) +
                   int'($urandom_range(0, 2 * int'(cur.backlash_amount))) + 1;
            roll = $urandom_range(0, 99);
            if (roll < 45) begin
                issue_command(CMD_LOAD, near_target(span), 1'($urandom_range(0, 1)));
                repeat ($urandom_range(4, 40))
                    issue_command(CMD_TICK, $urandom(), 1'($urandom_range(0, 9) == 0));
            end else if (roll < 65) begin
                issue_command(CMD_SLEW_REQ, $urandom(), 1'($urandom_range(0, 1)));
                repeat ($urandom_range(3, 20))
                    issue_command(CMD_TICK, $urandom(), 1'($urandom_range(0, 9) < 3));
                if ($urandom_range(0, 1) != 0)
                    issue_command(CMD_SLEW_REQ, $urandom(), 1'($urandom_range(0, 1)));
                repeat ($urandom_range(0, 4))
                    issue_command(CMD_TICK, $urandom(), 1'($urandom_range(0, 1)));
                issue_command(CMD_TRACK, $urandom(), 1'($urandom_range(0, 1)));
            end else if (roll < 85) begin
                repeat ($urandom_range(10, 40))
                    issue_command(CMD_TICK, $urandom(), 1'b0);
            end else begin
                issue_command(t_cmd'($urandom_range(0, 3)), $urandom(),
                              1'($urandom_range(0, 1)));
            end
            if ($urandom_range(0, 99) < 3)
                wait_drained();
        end

        wait_drained();
        repeat (5) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+sv
sv/sdgb_pkg.sv
sv/sdgb_regs.sv
sv/step_dir_generator_backlash.sv
bench/step_dir_checker.sv
bench/testbench.sv
